// ===== rtl/core/sts_pkg.sv =====
// sts_pkg: shared types and constants for the sorted table search core.
// No dependencies; imported by sts_table_mem, sts_search_ctrl and the top level.
`default_nettype none
package sts_pkg;

  // Default geometry of the table.
  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;
  localparam int unsigned DEFAULT_VALUE_WIDTH = 32;

  // Fixed widths of the stream and register fields.
  localparam int unsigned CMD_W        = 1;
  localparam int unsigned ENTRY_IDX_W  = 10;
  localparam int unsigned ITEM_VALUE_W = 32;
  localparam int unsigned POSITION_W   = 10;
  localparam int unsigned COUNT_REG_W  = 11;
  localparam int unsigned S_TDATA_W    = 48;
  localparam int unsigned M_TDATA_W    = 16;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  // Command codes carried in s_tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } command_t;

  // Register index (byte address divided by four).
  localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

  // Memory port controls from the sequencer to the table.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/sts_table_mem.sv =====
// sts_table_mem: single-port synchronous table memory with a registered read.
// Depends on sts_pkg for the port control struct.
`default_nettype none
module sts_table_mem #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire sts_pkg::mem_ctl_t      mem_ctl,
  input  wire logic [IDX_W-1:0]       addr,
  input  wire logic [VALUE_WIDTH-1:0] wdata,
  output logic      [VALUE_WIDTH-1:0] rdata
);
  import sts_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (mem_ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sts_search_ctrl.sv =====
// sts_search_ctrl: load/search sequencer and result register.
// Depends on sts_pkg; drives sts_table_mem one probe per cycle.
`default_nettype none
module sts_search_ctrl #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item side
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire sts_pkg::command_t           command,
  input  wire logic [sts_pkg::ENTRY_IDX_W-1:0] entry_index,
  input  wire logic [VALUE_WIDTH-1:0]      item_key,
  input  wire logic [CNT_W-1:0]            search_count,
  // table port
  output sts_pkg::mem_ctl_t                mem_ctl,
  output logic      [IDX_W-1:0]            mem_addr,
  output logic      [VALUE_WIDTH-1:0]      mem_wdata,
  input  wire logic [VALUE_WIDTH-1:0]      mem_rdata,
  // result side
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic      [sts_pkg::POSITION_W-1:0] out_position
);
  import sts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;
  logic [CNT_W-1:0]       mid;
  logic                   pending;
  logic                   hit_eq;
  logic [VALUE_WIDTH-1:0] key;

  logic                   accept;
  logic                   load_ok;
  logic                   probe_lt;
  logic                   take_lo;
  logic                   take_hi;
  logic [CNT_W-1:0]       lo_next;
  logic [CNT_W-1:0]       hi_next;
  logic [CNT_W-1:0]       mid_next;
  logic                   hit_eq_next;
  logic                   more;
  logic                   out_free;
  logic                   result_load;

  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign load_ok     = (32'(entry_index) < TABLE_DEPTH);
  assign out_free    = !out_valid || out_ready;
  assign result_load = (state == ST_FINISH) && out_free;

  // Fold in the probe issued last cycle, then pick the next midpoint.
  always_comb begin
    probe_lt    = (mem_rdata < key);
    take_lo     = pending && probe_lt;
    take_hi     = pending && !probe_lt;
    lo_next     = take_lo ? mid + CNT_W'(1) : lo;
    hi_next     = take_hi ? mid : hi;
    hit_eq_next = take_hi ? (mem_rdata == key) : hit_eq;
    mid_next    = lo_next + ((hi_next - lo_next) >> 1);
    more        = (lo_next < hi_next);
  end

  always_comb begin
    mem_ctl.wr_en = accept && (command == CMD_LOAD) && load_ok;
    mem_ctl.rd_en = (state == ST_SEARCH) && more;
    mem_wdata     = item_key;
    if (state == ST_IDLE) begin
      mem_addr = IDX_W'(entry_index);
    end else begin
      mem_addr = IDX_W'(mid_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (command == CMD_SEARCH)) begin
            lo      <= '0;
            hi      <= search_count;
            key     <= item_key;
            hit_eq  <= 1'b0;
            pending <= 1'b0;
            state   <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          lo      <= lo_next;
          hi      <= hi_next;
          mid     <= mid_next;
          hit_eq  <= hit_eq_next;
          pending <= more;
          if (!more) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // the last probe that lowered hi looked at the final bound
          if (result_load) begin
            out_found    <= hit_eq;
            out_position <= hit_eq ? POSITION_W'(lo) : '0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Loads and probes never share a cycle, so no forwarding is needed.
  a_no_wr_in_search: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr_en |-> (state == ST_IDLE))
    else $error("table write outside idle");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) && pending |-> (lo <= mid) && (mid < hi))
    else $error("probe outside search window");

  a_probe_follows: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.rd_en |=> (state == ST_SEARCH) && pending)
    else $error("probe read not consumed");

  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> (out_position == '0))
    else $error("miss reported with nonzero position");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_table_search_core.sv =====
// sorted_table_search_core: top level of the sorted table search block.
// Depends on sts_pkg, sts_table_mem and sts_search_ctrl.
//
// Usage:
//   The slave stream carries one word per item. s_tuser holds the command
//   (load or search); s_tdata holds entry_index and item_value. A load
//   writes item_value into the table at entry_index and returns nothing.
//   A search looks for the lowest index among the first entry_count entries
//   whose value equals item_value and returns one word on the master
//   stream: found and position (position is zero on a miss).
//   entry_count is set through the APB port at byte address 0; write it
//   only while no search is in flight. Software keeps the table sorted.
// Sequence:
//   A load is written into the table as it is accepted. A search steps
//   through accepting the item, one table read per halving of the window,
//   folding in the last probe and loading the result register. The table
//   has a single read port, which serialises the probes; one item is in
//   work at a time.
// Reset:
//   rst clears entry_count to zero, the sequencer to idle and the result
//   register to empty. The table itself is not cleared.
// Stall:
//   A finished result waits in the output register while m_tready is low;
//   loads still go through, and a following search runs to its end and
//   then holds until the output register frees up.
`default_nettype none
module sorted_table_search_core #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = sts_pkg::DEFAULT_VALUE_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item stream in
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [sts_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_index[9:0], item_value[41:10]
  input  wire logic [sts_pkg::CMD_W-1:0]       s_tuser,  // command[0]
  // result stream out
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [sts_pkg::M_TDATA_W-1:0]   m_tdata,  // found[0], position[10:1]
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sts_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [sts_pkg::PDATA_W-1:0]     pwdata,
  output logic      [sts_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready
);
  import sts_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [COUNT_REG_W-1:0]  entry_count;
  logic                    cfg_write;
  logic                    count_sel;

  logic [ENTRY_IDX_W-1:0]  entry_index;
  logic [ITEM_VALUE_W-1:0] item_value;
  logic [VALUE_WIDTH-1:0]  item_raw;
  logic [VALUE_WIDTH-1:0]  item_key;
  logic [CNT_W-1:0]        search_count;

  mem_ctl_t                mem_ctl;
  logic [IDX_W-1:0]        mem_addr;
  logic [VALUE_WIDTH-1:0]  mem_wdata;
  logic [VALUE_WIDTH-1:0]  mem_rdata;

  logic                    out_found;
  logic [POSITION_W-1:0]   out_position;

  // ---------------- configuration register ----------------
  assign pready    = 1'b1;
  assign count_sel = (paddr[PADDR_W-1] == REG_ENTRY_COUNT);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write && count_sel) begin
      entry_count <= pwdata[COUNT_REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (count_sel) begin
      prdata = PDATA_W'(entry_count);
    end
  end

  // Saturate the searched count at the table depth.
  assign search_count = (32'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(entry_count);

  // ---------------- item unpacking ----------------
  assign entry_index = s_tdata[ENTRY_IDX_W-1:0];
  assign item_value  = s_tdata[ENTRY_IDX_W +: ITEM_VALUE_W];

  // Sign-extend a signed item_value into a wider table word; otherwise keep its low VALUE_WIDTH bits.
  generate
    if (VALUE_WIDTH <= ITEM_VALUE_W) begin : g_value_narrow
      assign item_raw = item_value[VALUE_WIDTH-1:0];
    end else begin : g_value_wide
      assign item_raw = {{(VALUE_WIDTH - ITEM_VALUE_W){item_value[ITEM_VALUE_W-1]}},
                         item_value};
    end
  endgenerate

  // Flip the sign bit: unsigned order of keys equals signed order of values.
  assign item_key = {~item_raw[VALUE_WIDTH-1], item_raw[VALUE_WIDTH-2:0]};

  // ---------------- datapath ----------------
  sts_search_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .command      (command_t'(s_tuser)),
    .entry_index  (entry_index),
    .item_key     (item_key),
    .search_count (search_count),
    .mem_ctl      (mem_ctl),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_found    (out_found),
    .out_position (out_position)
  );

  sts_table_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata)
  );

  // ---------------- result packing ----------------
  assign m_tdata = {{(M_TDATA_W - POSITION_W - 1){1'b0}}, out_position, out_found};

endmodule
`default_nettype wire

// ===== bench/sorted_table_search_core_tb.sv =====
// Testbench for sorted_table_search_core: loads sorted tables, searches them and checks
// every result word against an in-bench lower-bound search over a mirror of the table.
// Depends on sts_pkg and the sorted_table_search_core RTL only.
`timescale 1ns / 100ps
module sorted_table_search_core_tb;
  import sts_pkg::*;

  localparam int unsigned TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 10;
  // Margin after the last result before touching the register.
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF_LEN = 300;
  localparam longint      VALUE_MAX    = 64'sd2147483647;
  localparam longint      VALUE_MIN    = -VALUE_MAX - 1;
  localparam longint      PATH_STEP    = 64'sd4000000;

  typedef struct packed {
    logic                  found;
    logic [POSITION_W-1:0] position;
  } lookup_t;

  logic                   clk     = 1'b0;
  logic                   rst     = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;     // entry_index[9:0], item_value[41:10]
  logic [CMD_W-1:0]       s_tuser = CMD_LOAD; // command[0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;           // found[0], position[10:1]
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_W-1:0]     paddr   = '0;
  logic [PDATA_W-1:0]     pwdata  = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  // Mirror of the block: table contents and the entry_count register.
  logic signed [ITEM_VALUE_W-1:0] entry_mirror [TABLE_DEPTH];
  logic [COUNT_REG_W-1:0]         count_mirror = '0;
  lookup_t                        lookup_results [$];

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned items_sent      = 0;
  int unsigned mismatch_count  = 0;
  // Entries 0..written_span-1 have all been loaded by the random rounds.
  int unsigned written_span    = 0;

  sorted_table_search_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Lower-bound binary search over the mirror, same probe order as the block.
  // Counts above the table depth saturate; an empty window is a miss at zero.
  function automatic lookup_t predict_lookup(input logic signed [ITEM_VALUE_W-1:0] target);
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lookup_t     res;
    span = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
    lo   = 0;
    hi   = span;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (entry_mirror[mid] < target) lo = mid + 1;
      else hi = mid;
    end
    res.found    = (lo < span) && (entry_mirror[lo] == target);
    res.position = res.found ? POSITION_W'(lo) : '0;
    return res;
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // between back-to-back words; drop it only while idling.
  task automatic send_word(input command_t cmd, input logic [ENTRY_IDX_W-1:0] idx,
                           input logic [ITEM_VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(S_TDATA_W - ITEM_VALUE_W - ENTRY_IDX_W){1'b0}}, value, idx};
    do @(posedge clk); while (!s_tready);
    // Word accepted at this edge: update the mirror in stream order.
    items_sent++;
    if (cmd == CMD_LOAD) entry_mirror[idx] = value;
    else lookup_results.insert(lookup_results.size(), predict_lookup(value));
  endtask

  // A search ignores entry_index, so toggle it freely.
  task automatic search_for(input logic [ITEM_VALUE_W-1:0] target);
    send_word(CMD_SEARCH, ENTRY_IDX_W'($urandom_range(TABLE_DEPTH - 1)), target);
  endtask

  // Let every expected result drain, then give trailing loads time to land.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (lookup_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write entry_count while the block is idle, then read it back.
  task automatic set_entry_count(input logic [COUNT_REG_W-1:0] count);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ENTRY_COUNT, 2'b00};
    pwdata  <= {{(PDATA_W - COUNT_REG_W){1'b0}}, count};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    count_mirror = count;
    // Go straight into the setup phase of the readback.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(PDATA_W - COUNT_REG_W){1'b0}}, count})
      report_mismatch($sformatf("entry_count readback %0h, wrote %0h", prdata, count));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load indexes 0..n-1 with a nondecreasing run; some steps are zero so that
  // duplicates appear, and the run clamps at the largest value.
  task automatic load_sorted_run(input int unsigned n, input longint start,
                                 input int unsigned max_step);
    longint level;
    level = start;
    for (int unsigned i = 0; i < n; i++) begin
      send_word(CMD_LOAD, ENTRY_IDX_W'(i), ITEM_VALUE_W'(level));
      if ($urandom_range(3) != 0) level += longint'($urandom_range(max_step));
      if (level > VALUE_MAX) level = VALUE_MAX;
    end
  endtask

  // Ascending value for a full-depth table: both extremes at the two ends.
  function automatic logic [ITEM_VALUE_W-1:0] path_value(input int unsigned idx);
    longint level;
    if (idx == TABLE_DEPTH - 1) level = VALUE_MAX;
    else level = VALUE_MIN + longint'(idx) * PATH_STEP;
    return ITEM_VALUE_W'(level);
  endfunction

  // Load every entry that a full-depth search probes when it always turns
  // the same way: down toward index zero, or up toward the top index.
  task automatic load_probe_path(input bit go_up);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = TABLE_DEPTH;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      send_word(CMD_LOAD, ENTRY_IDX_W'(mid), path_value(mid));
      if (go_up) lo = mid + 1;
      else hi = mid;
    end
  endtask

  // Mostly hit existing entries or their neighbors, sometimes anything at all.
  function automatic logic [ITEM_VALUE_W-1:0] pick_target(input int unsigned span);
    logic [ITEM_VALUE_W-1:0] target;
    int unsigned             sel;
    sel = $urandom_range(9);
    if (span == 0 || sel >= 8) begin
      target = $urandom;
    end else begin
      target = entry_mirror[$urandom_range(span - 1)];
      if (sel == 6) target = target + 1;
      else if (sel == 7) target = target - 1;
    end
    return target;
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // entry_count is zero out of reset: every search misses without probing.
  task automatic test_empty_table();
    set_idling(14, 14);
    search_for(32'h0000_0000);
    search_for(32'h8000_0000);
    search_for(32'h7FFF_FFFF);
  endtask

  // Small hand-built table with both extremes, duplicates and a last-element hit.
  task automatic test_directed_edges();
    send_word(CMD_LOAD, 10'd0, 32'h8000_0000);
    send_word(CMD_LOAD, 10'd1, 32'h8000_0000);
    send_word(CMD_LOAD, 10'd2, 32'hFFFF_FFFF);
    send_word(CMD_LOAD, 10'd3, 32'h0000_0000);
    send_word(CMD_LOAD, 10'd4, 32'h0000_0000);
    send_word(CMD_LOAD, 10'd5, 32'h0000_0005);
    send_word(CMD_LOAD, 10'd6, 32'h7FFF_FFFE);
    send_word(CMD_LOAD, 10'd7, 32'h7FFF_FFFF);
    send_word(CMD_LOAD, 10'd1023, 32'h5A5A_A5A5);
    set_entry_count(11'd8);
    search_for(32'h8000_0000);  // duplicate at the bottom: lowest index
    search_for(32'hFFFF_FFFF);
    search_for(32'h0000_0000);  // duplicate in the middle
    search_for(32'h0000_0005);
    search_for(32'h7FFF_FFFF);  // last element
    search_for(32'h7FFF_FFFE);
    search_for(32'h0000_0001);  // miss between entries
    search_for(32'hFFFF_FFFE);
    set_entry_count(11'd1);
    search_for(32'h8000_0000);
    search_for(32'hFFFF_FFFF);  // present at index 2 but outside the window
  endtask

  // Full-depth window: load only the two extreme probe paths, then search for
  // targets at the bottom and at the top, which never leave those paths.
  task automatic test_full_table();
    set_idling(0, 0);
    load_probe_path(1'b0);
    load_probe_path(1'b1);
    set_entry_count(COUNT_REG_W'(TABLE_DEPTH));
    search_for(entry_mirror[0]);
    search_for(entry_mirror[TABLE_DEPTH - 1]);
    search_for(entry_mirror[TABLE_DEPTH - 2] + 1);  // above all but the top: miss
    search_for(ITEM_VALUE_W'(VALUE_MAX));
    search_for(ITEM_VALUE_W'(VALUE_MIN));
    // Counts above the depth saturate to the full table.
    set_entry_count({COUNT_REG_W{1'b1}});
    search_for(entry_mirror[TABLE_DEPTH - 1]);
    search_for(entry_mirror[0]);
    set_entry_count(COUNT_REG_W'(TABLE_DEPTH + 1));
    search_for(entry_mirror[TABLE_DEPTH - 1]);
    search_for(entry_mirror[TABLE_DEPTH - 2] + 1);
  endtask

  // One round: reload a short prefix, pick a count, then a burst of searches
  // with a few stray loads mixed in.
  task automatic run_lookup_round();
    int unsigned n;
    int unsigned span;
    int unsigned sel;
    longint      start;
    int unsigned max_step;
    n = ($urandom_range(15) == 0) ? $urandom_range(25, 120) : $urandom_range(24);
    case ($urandom_range(3))
      0: start = VALUE_MIN;
      1: start = -longint'($urandom_range(64));
      2: start = VALUE_MAX - longint'($urandom_range(40));
      default: start = longint'($signed($urandom));
    endcase
    case ($urandom_range(2))
      0: max_step = 3;
      1: max_step = 1000;
      default: max_step = 32'hFFFF_FFFF;
    endcase
    if ($urandom_range(9) == 0) begin
      // Scrambled prefix: the result is whatever the probe sequence lands on.
      for (int unsigned i = 0; i < n; i++) send_word(CMD_LOAD, ENTRY_IDX_W'(i), $urandom);
    end else begin
      load_sorted_run(n, start, max_step);
    end
    if (n > written_span) written_span = n;
    // A window past the fresh run reaches older, loaded entries only.
    sel = $urandom_range(11);
    if (sel == 0) set_entry_count(COUNT_REG_W'($urandom_range(n, written_span)));
    else if (sel == 1) set_entry_count('0);
    else set_entry_count(COUNT_REG_W'(n));
    span = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
    repeat ($urandom_range(6, 14)) begin
      if ($urandom_range(9) == 0)
        send_word(CMD_LOAD, ENTRY_IDX_W'($urandom_range(TABLE_DEPTH - 1)), $urandom);
      search_for(pick_target(span));
    end
  endtask

  task automatic test_random_mix(input int unsigned send_pct, input int unsigned recv_pct,
                                 input int unsigned item_goal);
    int unsigned first_item;
    set_idling(send_pct, recv_pct);
    first_item = items_sent;
    while (items_sent - first_item < item_goal) run_lookup_round();
  endtask

  // Hold the result stream off for a long stretch while searches keep coming,
  // so the output register fills and the input stalls; loads go to the
  // unsearched part so the window stays sorted.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    load_sorted_run(16, -longint'($urandom_range(1000)), 50);
    set_entry_count(11'd16);
    search_for(pick_target(16));
    search_for(pick_target(16));
    hold_off_cycles = HOLD_OFF_LEN;
    for (int unsigned i = 0; i < 24; i++) begin
      if (i % 4 == 3)
        send_word(CMD_LOAD, ENTRY_IDX_W'($urandom_range(16, TABLE_DEPTH - 1)), $urandom);
      else
        search_for(pick_target(16));
    end
  endtask

  // Receiver: stall at random, or hold off completely while a stretch is pending.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result word with the oldest pending search.
  always @(posedge clk) begin : check_results
    lookup_t               want;
    logic                  got_found;
    logic [POSITION_W-1:0] got_position;
    if (!rst && m_tvalid && m_tready) begin
      got_found    = m_tdata[0];
      got_position = m_tdata[POSITION_W:1];
      if (lookup_results.size() == 0) begin
        report_mismatch($sformatf("result word %0h with no search pending", m_tdata));
      end else begin
        want = lookup_results.pop_front();
        if (got_found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", got_found, want.found));
        if (got_position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", got_position, want.position));
      end
    end
  end

  // Watchdog: end the run once nothing has moved on any port for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("sorted_table_search_core_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed_edges();
    test_full_table();
    test_random_mix(0, 0, 150);
    test_random_mix(80, 0, 150);
    test_random_mix(0, 80, 150);
    test_random_mix(14, 14, 150);
    test_output_backpressure();
    settle();
    if (mismatch_count == 0) $display("sorted_table_search_core_tb: PASS");
    else $display("sorted_table_search_core_tb: FAIL");
    $finish;
  end

endmodule
